### rtl/core/fftwv_pkg.sv
`timescale 1ns / 1ps

package fftwv_pkg;

  localparam int IDX_W      = 30;
  localparam int SZ_W       = 11;
  localparam int CRD_W      = 10;
  localparam int CZ_W       = 11;
  localparam int ZG_W       = 31;
  localparam int SCL_W      = 32;
  localparam int WAVE_W     = 31;
  localparam int SQ_W       = 60;
  localparam int PROD_W     = SZ_W + SCL_W;
  localparam int SQP_W      = 2 * WAVE_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = IDX_W / DIV_STEPS;
  localparam int NAXES      = 3;
  localparam int FRAC_SHIFT = 12;

  localparam logic [2:0] CFG_SIZE_X   = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y   = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z   = 3'd2;
  localparam logic [2:0] CFG_Z_OFFSET = 3'd3;
  localparam logic [2:0] CFG_SCALE_X  = 3'd4;
  localparam logic [2:0] CFG_SCALE_Y  = 3'd5;
  localparam logic [2:0] CFG_SCALE_Z  = 3'd6;

  localparam logic [WAVE_W-1:0] WAVE_POS_MAX = 31'h3FFF_FFFF;
  localparam logic [WAVE_W-1:0] WAVE_NEG_MAG = 31'h4000_0000;
  localparam logic [SQ_W-1:0]   SQ_MAX       = {SQ_W{1'b1}};
  localparam logic [CZ_W-1:0]   CZ_MAX       = {CZ_W{1'b1}};

  typedef struct packed {
    logic [CRD_W-1:0] coord_x;
    logic [CRD_W-1:0] coord_y;
    logic [CZ_W-1:0]  coord_z;
    logic             nyquist;
    logic             outside;
  } side_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [SZ_W:0] div_step(logic [SZ_W-1:0] rem, logic b,
                                             logic [SZ_W-1:0] d);
    logic [SZ_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, SZ_W'(t - {1'b0, d})};
    end else begin
      div_step = {1'b0, t[SZ_W-1:0]};
    end
  endfunction

  // signed frequency fold: {negative, magnitude}
  function automatic logic [SZ_W:0] fold(logic [SZ_W-1:0] m, logic [SZ_W-1:0] n);
    logic [SZ_W-1:0] mag;
    if ({m, 1'b0} < {1'b0, n}) begin
      fold = {1'b0, m};
    end else begin
      mag  = n - m;
      fold = {(mag != '0), mag};
    end
  endfunction

endpackage

### rtl/core/fft_wavevector_from_index.sv
`timescale 1ns / 1ps

// Channel  | ports                                   | handshake
// ---------+-----------------------------------------+------------------------------
// request  | start, busy, in_local_index             | taken when start && !busy
// result   | out_valid, out_coord_*, out_wave_*, ... | one-cycle strobe, no backpressure
// config   | cfg_we, cfg_index, cfg_wdata            | written when cfg_we
//
// One request per cycle: two 15-stage restoring
// dividers (2 quotient bits per stage, by size_x then size_y), then z offset,
// fold, scale multiply, saturate, square and sum stages.
// busy never rises; the result side cannot stall, so nothing is held.
// Synchronous active-low reset clears the stage valid bits and loads the
// register defaults.

module fft_wavevector_from_index #(
  parameter int MAX_AXIS_SIZE = 1024,
  parameter int AXES          = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [29:0] in_local_index,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic [9:0]  out_coord_x,
  output logic [9:0]  out_coord_y,
  output logic [10:0] out_coord_z,
  output logic signed [30:0] out_wave_x,
  output logic signed [30:0] out_wave_y,
  output logic signed [30:0] out_wave_z,
  output logic [59:0] out_wave_squared,
  output logic        out_nyquist,
  output logic        out_outside_grid
);

  localparam int DS = fftwv_pkg::DIV_STAGES;
  localparam int SW = fftwv_pkg::SZ_W;
  localparam int NA = fftwv_pkg::NAXES;
  localparam int WW = fftwv_pkg::WAVE_W;

  // ---------------- configuration ----------------
  logic [SW-1:0] size_x_r, size_y_r, size_z_r;
  logic [9:0]    z_offset_r;
  logic [31:0]   scale_r [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r   <= 11'd64;
      size_y_r   <= 11'd64;
      size_z_r   <= 11'd64;
      z_offset_r <= '0;
      scale_r[0] <= '0;
      scale_r[1] <= '0;
      scale_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fftwv_pkg::CFG_SIZE_X:   size_x_r   <= cfg_wdata[SW-1:0];
        fftwv_pkg::CFG_SIZE_Y:   size_y_r   <= cfg_wdata[SW-1:0];
        fftwv_pkg::CFG_SIZE_Z:   size_z_r   <= cfg_wdata[SW-1:0];
        fftwv_pkg::CFG_Z_OFFSET: z_offset_r <= cfg_wdata[9:0];
        fftwv_pkg::CFG_SCALE_X:  scale_r[0] <= cfg_wdata;
        fftwv_pkg::CFG_SCALE_Y:  scale_r[1] <= cfg_wdata;
        fftwv_pkg::CFG_SCALE_Z:  scale_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective axis size: unused axis or zero means 1, clamp at the maximum
  function automatic logic [SW-1:0] eff_size(logic [SW-1:0] s, int axis);
    if (axis >= AXES || s == '0) begin
      eff_size = SW'(1);
    end else if (int'(s) > MAX_AXIS_SIZE) begin
      eff_size = SW'(MAX_AXIS_SIZE);
    end else begin
      eff_size = s;
    end
  endfunction

  logic [SW-1:0] nx, ny, nz;
  assign nx = eff_size(size_x_r, 0);
  assign ny = eff_size(size_y_r, 1);
  assign nz = eff_size(size_z_r, 2);

  assign busy = 1'b0;

  // ---------------- divider 1: index / nx ----------------
  logic          d1_v_r [1:DS];
  logic [29:0]   d1_w_r [1:DS];
  logic [SW-1:0] d1_r_r [1:DS];

  for (genvar i = 1; i <= DS; i++) begin : g_div1
    logic          v_nxt;
    logic [29:0]   w_in;
    logic [SW-1:0] r_in;
    logic [SW:0]   s1, s2;
    if (i == 1) begin : g_src
      assign v_nxt = start;
      assign w_in  = in_local_index;
      assign r_in  = '0;
    end else begin : g_src
      assign v_nxt = d1_v_r[i-1];
      assign w_in  = d1_w_r[i-1];
      assign r_in  = d1_r_r[i-1];
    end
    assign s1 = fftwv_pkg::div_step(r_in, w_in[29], nx);
    assign s2 = fftwv_pkg::div_step(s1[SW-1:0], w_in[28], nx);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[i] <= 1'b0;
      end else begin
        d1_v_r[i] <= v_nxt;
      end
    end
    always_ff @(posedge clk) begin
      d1_w_r[i] <= {w_in[27:0], s1[SW], s2[SW]};
      d1_r_r[i] <= s2[SW-1:0];
    end
  end

  // ---------------- divider 2: quotient / ny, x rides along ----------------
  logic          d2_v_r [1:DS];
  logic [29:0]   d2_w_r [1:DS];
  logic [SW-1:0] d2_r_r [1:DS];
  logic [SW-1:0] d2_x_r [1:DS];

  for (genvar i = 1; i <= DS; i++) begin : g_div2
    logic          v_nxt;
    logic [29:0]   w_in;
    logic [SW-1:0] r_in;
    logic [SW-1:0] x_in;
    logic [SW:0]   s1, s2;
    if (i == 1) begin : g_src
      assign v_nxt = d1_v_r[DS];
      assign w_in  = d1_w_r[DS];
      assign r_in  = '0;
      assign x_in  = d1_r_r[DS];
    end else begin : g_src
      assign v_nxt = d2_v_r[i-1];
      assign w_in  = d2_w_r[i-1];
      assign r_in  = d2_r_r[i-1];
      assign x_in  = d2_x_r[i-1];
    end
    assign s1 = fftwv_pkg::div_step(r_in, w_in[29], ny);
    assign s2 = fftwv_pkg::div_step(s1[SW-1:0], w_in[28], ny);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v_r[i] <= 1'b0;
      end else begin
        d2_v_r[i] <= v_nxt;
      end
    end
    always_ff @(posedge clk) begin
      d2_w_r[i] <= {w_in[27:0], s1[SW], s2[SW]};
      d2_r_r[i] <= s2[SW-1:0];
      d2_x_r[i] <= x_in;
    end
  end

  // ---------------- E: global z ----------------
  logic          e_v_r;
  logic [SW-1:0] e_x_r, e_y_r;
  logic [30:0]   e_zg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else        e_v_r <= d2_v_r[DS];
  end
  always_ff @(posedge clk) begin
    e_x_r  <= d2_x_r[DS];
    e_y_r  <= d2_r_r[DS];
    e_zg_r <= {1'b0, d2_w_r[DS]} + 31'(z_offset_r);
  end

  // ---------------- F: range, Nyquist, fold ----------------
  logic             f_v_r;
  fftwv_pkg::side_t f_side_r, f_side_nxt;
  logic [SW-1:0]    f_mag_r [NA];
  logic             f_neg_r [NA];
  logic [SW-1:0]    f_mag_nxt [NA];
  logic             f_neg_nxt [NA];

  always_comb begin
    logic [SW-1:0] m [NA];
    logic [SW-1:0] n [NA];
    logic [SW:0]   fd;
    logic          kill;
    m[0] = e_x_r;
    m[1] = e_y_r;
    m[2] = e_zg_r[SW-1:0];
    n[0] = nx;
    n[1] = ny;
    n[2] = nz;
    f_side_nxt.coord_x = e_x_r[fftwv_pkg::CRD_W-1:0];
    f_side_nxt.coord_y = e_y_r[fftwv_pkg::CRD_W-1:0];
    f_side_nxt.coord_z = (e_zg_r > 31'(fftwv_pkg::CZ_MAX)) ? fftwv_pkg::CZ_MAX
                                                            : e_zg_r[10:0];
    f_side_nxt.outside = (e_zg_r >= 31'(nz));
    // even axis with 2*m == n; z only meaningful inside the grid
    f_side_nxt.nyquist = !f_side_nxt.outside &&
                         (({m[0], 1'b0} == {1'b0, n[0]}) ||
                          ({m[1], 1'b0} == {1'b0, n[1]}) ||
                          ({m[2], 1'b0} == {1'b0, n[2]}));
    kill = f_side_nxt.outside || f_side_nxt.nyquist;
    for (int a = 0; a < NA; a++) begin
      fd = fftwv_pkg::fold(m[a], n[a]);
      f_mag_nxt[a] = kill ? '0 : fd[SW-1:0];
      f_neg_nxt[a] = kill ? 1'b0 : fd[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else        f_v_r <= e_v_r;
  end
  always_ff @(posedge clk) begin
    f_side_r <= f_side_nxt;
    for (int a = 0; a < NA; a++) begin
      f_mag_r[a] <= f_mag_nxt[a];
      f_neg_r[a] <= f_neg_nxt[a];
    end
  end

  // ---------------- M: magnitude times scale, Q.12 ----------------
  logic             m_v_r;
  fftwv_pkg::side_t m_side_r;
  logic [WW-1:0]    m_prod_r [NA];
  logic             m_neg_r [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else        m_v_r <= f_v_r;
  end
  always_ff @(posedge clk) begin
    logic [fftwv_pkg::PROD_W-1:0] p;
    m_side_r <= f_side_r;
    for (int a = 0; a < NA; a++) begin
      p = fftwv_pkg::PROD_W'(f_mag_r[a]) * fftwv_pkg::PROD_W'(scale_r[a]);
      m_prod_r[a] <= p[fftwv_pkg::PROD_W-1:fftwv_pkg::FRAC_SHIFT];
      m_neg_r[a]  <= f_neg_r[a];
    end
  end

  // ---------------- K: sign and saturate ----------------
  logic             k_v_r;
  fftwv_pkg::side_t k_side_r;
  logic [WW-1:0]    k_wave_r [NA];
  logic [WW-1:0]    k_abs_r  [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) k_v_r <= 1'b0;
    else        k_v_r <= m_v_r;
  end
  always_ff @(posedge clk) begin
    logic [WW-1:0] mg;
    k_side_r <= m_side_r;
    for (int a = 0; a < NA; a++) begin
      if (m_neg_r[a]) begin
        mg = (m_prod_r[a] > fftwv_pkg::WAVE_NEG_MAG) ? fftwv_pkg::WAVE_NEG_MAG
                                                      : m_prod_r[a];
        k_wave_r[a] <= ~mg + WW'(1);
      end else begin
        mg = (m_prod_r[a] > fftwv_pkg::WAVE_POS_MAX) ? fftwv_pkg::WAVE_POS_MAX
                                                      : m_prod_r[a];
        k_wave_r[a] <= mg;
      end
      k_abs_r[a] <= mg;
    end
  end

  // ---------------- S: squares ----------------
  logic                        s_v_r;
  fftwv_pkg::side_t            s_side_r;
  logic [WW-1:0]               s_wave_r [NA];
  logic [fftwv_pkg::SQP_W-1:0] s_sq_r   [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r <= 1'b0;
    else        s_v_r <= k_v_r;
  end
  always_ff @(posedge clk) begin
    s_side_r <= k_side_r;
    for (int a = 0; a < NA; a++) begin
      s_wave_r[a] <= k_wave_r[a];
      s_sq_r[a]   <= fftwv_pkg::SQP_W'(k_abs_r[a]) * fftwv_pkg::SQP_W'(k_abs_r[a]);
    end
  end

  // ---------------- O: sum, saturate, output register ----------------
  logic             o_v_r;
  fftwv_pkg::side_t o_side_r;
  logic [WW-1:0]    o_wave_r [NA];
  logic [59:0]      o_sq_r;
  logic [63:0]      o_sum;

  assign o_sum = 64'(s_sq_r[0]) + 64'(s_sq_r[1]) + 64'(s_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else        o_v_r <= s_v_r;
  end
  always_ff @(posedge clk) begin
    o_side_r <= s_side_r;
    for (int a = 0; a < NA; a++) o_wave_r[a] <= s_wave_r[a];
    o_sq_r <= (o_sum > 64'(fftwv_pkg::SQ_MAX)) ? fftwv_pkg::SQ_MAX : o_sum[59:0];
  end

  assign out_valid        = o_v_r;
  assign out_coord_x      = o_side_r.coord_x;
  assign out_coord_y      = o_side_r.coord_y;
  assign out_coord_z      = o_side_r.coord_z;
  assign out_wave_x       = $signed(o_wave_r[0]);
  assign out_wave_y       = $signed(o_wave_r[1]);
  assign out_wave_z       = $signed(o_wave_r[2]);
  assign out_wave_squared = o_sq_r;
  assign out_nyquist      = o_side_r.nyquist;
  assign out_outside_grid = o_side_r.outside;

`ifndef ASSERT_OFF
  // every accepted request is followed by a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##36 out_valid)
    else $error("result strobe missing after fixed latency");

  // flagged points carry no wavevector
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_nyquist || out_outside_grid)) |->
      (out_wave_x == 0 && out_wave_y == 0 && out_wave_z == 0 &&
       out_wave_squared == 0))
    else $error("nonzero wavevector on flagged point");

  // outside points are never Nyquist
  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_nyquist && out_outside_grid))
    else $error("nyquist and outside both set");
`endif

endmodule
